// File: rtl/core/lpht_pkg.sv
package lpht_pkg;

    localparam int CAPACITY  = 64;
    localparam int KEY_BYTES = 8;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int KEY_W     = 8 * KEY_BYTES;
    localparam int LEN_W     = 4;
    localparam int SIZE_W    = 7;
    localparam int SLOT_W    = 6;

    localparam logic [31:0] FNV_PRIME = 32'h0100_0193;
    localparam logic [31:0] FNV_SEED  = 32'h811C_9DC5;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOTFND = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_FIND   = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [LEN_W-1:0] len;
        logic [31:0]      value;
    } entry_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        entry_t           wdata;
        logic [IDX_W-1:0] raddr;
    } mem_req_t;

endpackage

// File: rtl/core/lpht_hash.sv
module lpht_hash
    import lpht_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [KEY_W-1:0]  key,
    input  logic [LEN_W-1:0]  len,
    output logic              done,
    output logic [31:0]       hash
);

    logic [31:0]      h_reg, h_next;
    logic [LEN_W-1:0] i_reg, i_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [7:0]       byte_sel;

    assign byte_sel = key[i_reg[2:0]*8 +: 8];

    always_comb
    begin
        h_next    = h_reg;
        i_next    = i_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            h_next    = FNV_SEED;
            i_next    = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (i_reg == len)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (len == '0)
                begin
                    h_next = '0;
                end
            end
            else
            begin
                h_next = (h_reg ^ {24'd0, byte_sel}) * FNV_PRIME;
                i_next = i_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg <= h_next;
        i_reg <= i_next;
    end

    assign done = done_reg;
    assign hash = h_reg;

endmodule

// File: rtl/core/lpht_store.sv
module lpht_store
    import lpht_pkg::*;
(
    input  logic     clk,
    input  mem_req_t req,
    output entry_t   rdata
);

    entry_t mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata <= mem[req.raddr];
    end

endmodule

// File: rtl/core/linear_probe_hash_table.sv
// Operation: FNV hashing of the key bytes, a bit-serial modulo, then a read
//   and a compare per probed slot over up to table_size slots, the output
//   state and a handoff that waits until the result is taken.
// Throughput: one transaction at a time; the time per transaction is set
//   by the serial FNV byte loop, the bit-serial modulo and the slot memory walk.
// Reset: asynchronous active low; clears the used bits, the entry count and
//   sets table_size to 64. Slot contents are undefined until written.
module linear_probe_hash_table
    import lpht_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [SIZE_W-1:0] cfg_wdata,
    input  logic              s_tvalid,
    output logic              s_tready,
    // tdata: key_bytes[63:0], key_length[67:64], value_handle[99:68], zero pad
    input  logic [103:0]      s_tdata,
    // tuser: kind
    input  logic              s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    // tdata: status[1:0], found_value[33:2], slot[39:34], key_hash[71:40]
    output logic [71:0]       m_tdata
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_HASH = 7'b0000010,
        S_MOD  = 7'b0000100,
        S_RD   = 7'b0001000,
        S_CMP  = 7'b0010000,
        S_OUT  = 7'b0100000,
        S_WAIT = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    logic [SIZE_W-1:0] tsize_reg;
    logic [CAPACITY-1:0] used_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              kind_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [31:0]       val_reg;
    logic [31:0]       rem_reg;
    logic [4:0]        mstep_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  n_reg;
    logic [CNT_W-1:0]  size_reg;
    logic [1:0]        st_reg;
    logic [31:0]       fv_reg;
    logic [IDX_W-1:0]  slot_reg;
    logic              mvalid_reg;
    logic [71:0]       mdata_reg;

    logic [LEN_W-1:0]  in_len;
    logic [KEY_W-1:0]  in_mask;
    logic              hdone;
    logic [31:0]       hash;
    mem_req_t          req;
    entry_t            rdata;
    logic [CNT_W-1:0]  eff;
    logic [38:0]       rem_ext;
    logic [38:0]       msub;
    logic [38:0]       mdiff;
    logic              mge;
    logic              match;
    logic [IDX_W-1:0]  idx_inc;

    assign in_len = (s_tdata[67:64] > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES)
                                                          : s_tdata[67:64];
    always_comb
    begin
        in_mask = '0;
        for (int b = 0; b < KEY_BYTES; b++)
        begin
            if (b < int'(in_len))
            begin
                in_mask[b*8 +: 8] = 8'hFF;
            end
        end
    end

    assign eff = (tsize_reg == '0) ? CNT_W'(1)
               : (tsize_reg > SIZE_W'(CAPACITY)) ? CNT_W'(CAPACITY) : CNT_W'(tsize_reg);

    assign s_tready = (state_reg == S_IDLE);

    lpht_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (s_tvalid && s_tready),
        .key   (key_reg),
        .len   (len_reg),
        .done  (hdone),
        .hash  (hash)
    );

    assign rem_ext = {7'd0, rem_reg};
    assign msub    = {32'd0, size_reg} << mstep_reg;
    assign mge     = (rem_ext >= msub);
    assign mdiff   = rem_ext - msub;
    assign match = used_reg[idx_reg] && (rdata.len == len_reg) && (rdata.key == key_reg);
    assign idx_inc = (CNT_W'(idx_reg) + 1'b1 == size_reg) ? '0 : idx_reg + 1'b1;

    always_comb
    begin
        req.we    = (state_reg == S_CMP) && (kind_reg == KIND_INSERT) && !used_reg[idx_reg];
        req.waddr = idx_reg;
        req.wdata = '{key: key_reg, len: len_reg, value: val_reg};
        req.raddr = idx_reg;
    end

    lpht_store u_store (
        .clk   (clk),
        .req   (req),
        .rdata (rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (s_tvalid) state_next = S_HASH;
            S_HASH: if (hdone) state_next = S_MOD;
            S_MOD:  if (mstep_reg == 5'd0) state_next = S_RD;
            S_RD:
            begin
                if ((kind_reg == KIND_INSERT && count_reg >= size_reg)
                    || (kind_reg == KIND_FIND && count_reg == '0)
                    || n_reg == size_reg)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if ((kind_reg == KIND_INSERT && !used_reg[idx_reg])
                    || (kind_reg == KIND_FIND && match))
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_OUT:  state_next = S_WAIT;
            S_WAIT: if (!mvalid_reg) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            tsize_reg  <= SIZE_W'(64);
            used_reg   <= '0;
            count_reg  <= '0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                tsize_reg <= cfg_wdata;
            end
            if (req.we)
            begin
                used_reg[idx_reg] <= 1'b1;
                count_reg         <= count_reg + 1'b1;
            end
            if (state_reg == S_OUT)
            begin
                mvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                mvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                kind_reg <= s_tuser;
                len_reg  <= in_len;
                key_reg  <= s_tdata[63:0] & in_mask;
                val_reg  <= s_tdata[99:68];
                size_reg <= eff;
            end
            S_HASH:
            begin
                rem_reg   <= hash;
                mstep_reg <= 5'd31;
            end
            S_MOD:
            begin
                if (mge)
                begin
                    rem_reg <= mdiff[31:0];
                end
                mstep_reg <= mstep_reg - 1'b1;
                if (mstep_reg == 5'd0)
                begin
                    idx_reg <= mge ? mdiff[IDX_W-1:0] : rem_reg[IDX_W-1:0];
                    n_reg   <= '0;
                    st_reg  <= (kind_reg == KIND_INSERT) ? ST_FULL : ST_NOTFND;
                    fv_reg  <= '0;
                    slot_reg <= '0;
                end
            end
            S_CMP:
            begin
                if (kind_reg == KIND_INSERT && !used_reg[idx_reg])
                begin
                    st_reg   <= ST_OK;
                    slot_reg <= idx_reg;
                end
                else if (kind_reg == KIND_FIND && match)
                begin
                    st_reg   <= ST_OK;
                    slot_reg <= idx_reg;
                    fv_reg   <= rdata.value;
                end
                else
                begin
                    idx_reg <= idx_inc;
                    n_reg   <= n_reg + 1'b1;
                end
            end
            S_OUT:
            begin
                mdata_reg <= {hash, SLOT_W'(slot_reg), fv_reg, st_reg};
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready || m_tready)
        else $error("input accepted while result pending");
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        CNT_W'($countones(used_reg)) == count_reg)
        else $error("entry count mismatch");
    a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
        req.we |=> used_reg[$past(idx_reg)])
        else $error("write did not mark slot used");

endmodule

// File: sim/lpht_monitor.sv
module lpht_monitor
    import lpht_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [SIZE_W-1:0] cfg_wdata,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [103:0]      s_tdata,
    input  logic              s_tuser,
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [71:0]       m_tdata,
    output int                errors,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0]       key_hash;
        logic [SLOT_W-1:0] slot;
        logic [31:0]       found_value;
        logic [1:0]        status;
    } reply_t;

    logic [KEY_W-1:0] shadow_key   [CAPACITY];
    logic [LEN_W-1:0] shadow_len   [CAPACITY];
    logic [31:0]      shadow_value [CAPACITY];
    logic             shadow_used  [CAPACITY];
    int               shadow_count;
    logic [SIZE_W-1:0] shadow_size;
    reply_t           expected_replies[$];

    assign pending = expected_replies.size();

    function automatic logic [31:0] fnv1a_hash(logic [KEY_W-1:0] k, int n);
        logic [31:0] h;
        h = FNV_SEED;
        if (n == 0)
            return 32'd0;
        for (int i = 0; i < n; i++)
            h = (h ^ {24'd0, k[8*i +: 8]}) * FNV_PRIME;
        return h;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    task automatic predict_lookup(logic kind, logic [KEY_W-1:0] raw_key,
                                  logic [LEN_W-1:0] raw_len, logic [31:0] value);
        reply_t r;
        int n;
        int size;
        int idx;
        logic [KEY_W-1:0] k;
        n = (raw_len > KEY_BYTES) ? KEY_BYTES : int'(raw_len);
        size = (shadow_size == 0) ? 1
             : (shadow_size > CAPACITY ? CAPACITY : int'(shadow_size));
        k = '0;
        for (int i = 0; i < n; i++)
            k[8*i +: 8] = raw_key[8*i +: 8];
        r = '0;
        r.key_hash = fnv1a_hash(k, n);
        r.status = ST_NOTFND;
        idx = int'(r.key_hash % 32'(size));
        if (kind == KIND_INSERT)
        begin
            r.status = ST_FULL;
            if (shadow_count < size)
            begin
                for (int p = 0; p < size; p++)
                begin
                    if (!shadow_used[idx])
                    begin
                        shadow_key[idx] = k;
                        shadow_len[idx] = LEN_W'(n);
                        shadow_value[idx] = value;
                        shadow_used[idx] = 1'b1;
                        shadow_count++;
                        r.status = ST_OK;
                        r.slot = SLOT_W'(idx);
                        break;
                    end
                    idx = (idx + 1) % size;
                end
            end
        end
        else if (shadow_count != 0)
        begin
            for (int p = 0; p < size; p++)
            begin
                if (shadow_used[idx] && shadow_len[idx] == LEN_W'(n) && shadow_key[idx] == k)
                begin
                    r.status = ST_OK;
                    r.slot = SLOT_W'(idx);
                    r.found_value = shadow_value[idx];
                    break;
                end
                idx = (idx + 1) % size;
            end
        end
        expected_replies.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        reply_t got;
        reply_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < CAPACITY; i++)
                shadow_used[i] = 1'b0;
            shadow_count = 0;
            shadow_size = 7'd64;
            expected_replies.delete();
            errors = 0;
        end
        else
        begin
            if (cfg_we)
                shadow_size = cfg_wdata;
            if (s_tvalid && s_tready)
                predict_lookup(s_tuser, s_tdata[63:0], s_tdata[67:64], s_tdata[99:68]);
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (expected_replies.size() == 0)
                begin
                    report("unexpected result", got.key_hash, 32'd0);
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (got.status != want.status)
                        report("status", 32'(got.status), 32'(want.status));
                    if (got.found_value != want.found_value)
                        report("found_value", got.found_value, want.found_value);
                    if (got.slot != want.slot)
                        report("slot", 32'(got.slot), 32'(want.slot));
                    if (got.key_hash != want.key_hash)
                        report("key_hash", got.key_hash, want.key_hash);
                end
            end
        end
    end
endmodule

// File: sim/tb_top.sv
module tb_top
    import lpht_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1000000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [SIZE_W-1:0] cfg_wdata = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [103:0]      s_tdata = '0;
    logic              s_tuser = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [71:0]       m_tdata;
    int                errors;
    int                pending;
    int                cycles = 0;
    bit                send_idle = 0;
    bit                recv_stall = 0;

    logic [KEY_W-1:0] known_keys[$];
    logic [LEN_W-1:0] known_lens[$];

    always #2 clk = ~clk;

    linear_probe_hash_table dut (
        .clk, .rst_n, .cfg_we, .cfg_wdata,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata
    );

    lpht_monitor checker_i (
        .clk, .rst_n, .cfg_we, .cfg_wdata,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata,
        .errors, .pending
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** linear_probe_hash_table: FAILED **");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (recv_stall && $urandom_range(99) < 54)
            m_tready <= 1'b0;
        else
            m_tready <= 1'b1;
    end

    task automatic send_op(logic kind, logic [KEY_W-1:0] k, logic [LEN_W-1:0] n,
                           logic [31:0] value);
        if (send_idle && $urandom_range(99) < 54)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {4'd0, value, n, k};
        if (kind == KIND_INSERT)
        begin
            known_keys.push_back(k);
            known_lens.push_back(n);
        end
        forever
        begin
            @(posedge clk);
            if (s_tready)
                break;
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic set_size(logic [SIZE_W-1:0] size);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= size;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_op();
        logic [KEY_W-1:0] k;
        logic [LEN_W-1:0] n;
        int pick;
        k = {$urandom, $urandom};
        n = ($urandom_range(9) == 0) ? LEN_W'($urandom_range(9, 15))
                                     : LEN_W'($urandom_range(0, 8));
        if ($urandom_range(99) < 15)
        begin
            send_op(KIND_INSERT, k, n, $urandom);
        end
        else
        begin
            if (known_keys.size() != 0 && $urandom_range(99) < 70)
            begin
                pick = int'($urandom_range(known_keys.size() - 1));
                n = known_lens[pick];
                for (int i = 0; i < KEY_BYTES; i++)
                    if (i < n)
                        k[8*i +: 8] = known_keys[pick][8*i +: 8];
                if (n >= KEY_BYTES && $urandom_range(1))
                    n = LEN_W'($urandom_range(8, 15));
                else if ($urandom_range(9) == 0)
                    n = n + 1'b1;
            end
            send_op(KIND_FIND, k, n, $urandom);
        end
    endtask

    initial
    begin
        logic [SIZE_W-1:0] sizes[12] = '{7'd3, 7'd64, 7'd1, 7'd127, 7'd20, 7'd0,
                                          7'd64, 7'd45, 7'd100, 7'd7, 7'd64, 7'd33};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_op(KIND_FIND, 64'h0123_4567_89AB_CDEF, 4'd8, 32'hFFFF_FFFF);
        send_op(KIND_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 32'h0000_0000);
        send_op(KIND_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'hFFFF_FFFF);
        send_op(KIND_INSERT, 64'h0000_0000_0000_0000, 4'd15, 32'h1234_5678);
        send_op(KIND_INSERT, 64'hDEAD_BEEF_0000_0061, 4'd1, 32'hAAAA_5555);
        send_op(KIND_INSERT, 64'h0000_0000_0000_0061, 4'd1, 32'h5555_AAAA);
        send_op(KIND_FIND, 64'h0000_0000_0000_0000, 4'd0, 32'd0);
        send_op(KIND_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 4'd12, 32'd0);
        send_op(KIND_FIND, 64'h0000_0000_0000_0000, 4'd8, 32'd0);
        send_op(KIND_FIND, 64'hFFFF_FFFF_FFFF_FF61, 4'd1, 32'd0);
        send_op(KIND_FIND, 64'h0000_0000_0000_0061, 4'd2, 32'd0);
        send_op(KIND_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 4'd7, 32'd0);
        set_size(7'd0);
        send_op(KIND_INSERT, 64'h0000_0000_0000_0062, 4'd1, 32'h0000_0001);
        send_op(KIND_FIND, 64'h0000_0000_0000_0061, 4'd1, 32'd0);
        send_op(KIND_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'd0);
        set_size(7'd127);
        send_op(KIND_INSERT, 64'h8000_0000_0000_0000, 4'd8, 32'h8000_0001);
        send_op(KIND_FIND, 64'h8000_0000_0000_0000, 4'd8, 32'd0);

        for (int p = 0; p < 12; p++)
        begin
            set_size(sizes[p]);
            send_idle = (p % 4 == 1) || (p % 4 == 3);
            recv_stall = (p % 4 == 2) || (p % 4 == 3);
            for (int i = 0; i < 90; i++)
            begin
                random_op();
                if (i == 45 && p == 5)
                    drain();
            end
        end

        drain();
        if (errors == 0 && pending == 0)
            $display("** linear_probe_hash_table: PASSED **");
        else
            $display("** linear_probe_hash_table: FAILED **");
        $finish;
    end
endmodule
